@@ sv/qrs_pkg.sv @@
// Shared constants for the quadratic root solver.
`default_nettype none

package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

endpackage

`default_nettype wire

@@ sv/qrs_sqrt_cell.sv @@
// One stage of the pipelined integer square root: resolves one result bit.
`default_nettype none

module qrs_sqrt_cell #(
    parameter int RW = 49,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [RW-1:0]   i_root,
    input  logic [RW+1:0]   i_rem,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [2*RW-1:0] o_rad,
    output logic [RW-1:0]   o_root,
    output logic [RW+1:0]   o_rem,
    output logic [PW-1:0]   o_pay
);

    logic            r_valid;
    logic [2*RW-1:0] r_rad, n_rad;
    logic [RW-1:0]   r_root, n_root;
    logic [RW+1:0]   r_rem, n_rem;
    logic [PW-1:0]   r_pay;
    logic [RW+3:0]   w_cur, w_trial, w_diff;
    logic            w_ge;

    always_comb begin
        w_cur   = {i_rem, i_rad[2*RW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_cur - w_trial;
        w_ge    = (w_cur >= w_trial);
        n_rem   = w_ge ? w_diff[RW+1:0] : w_cur[RW+1:0];
        n_root  = {i_root[RW-2:0], w_ge};
        n_rad   = {i_rad[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rad  <= n_rad;
        r_root <= n_root;
        r_rem  <= n_rem;
        r_pay  <= i_pay;
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
    assign o_pay   = r_pay;

endmodule

`default_nettype wire

@@ sv/qrs_div_cell.sv @@
// One stage of the pipelined restoring divider: one quotient bit for both roots.
`default_nettype none

module qrs_div_cell #(
    parameter int NW = 50,
    parameter int DW = 33,
    parameter int PW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_den,
    input  logic [NW-1:0] i_num0,
    input  logic [NW-1:0] i_num1,
    input  logic [NW-1:0] i_quo0,
    input  logic [NW-1:0] i_quo1,
    input  logic [DW-1:0] i_rem0,
    input  logic [DW-1:0] i_rem1,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [DW-1:0] o_den,
    output logic [NW-1:0] o_num0,
    output logic [NW-1:0] o_num1,
    output logic [NW-1:0] o_quo0,
    output logic [NW-1:0] o_quo1,
    output logic [DW-1:0] o_rem0,
    output logic [DW-1:0] o_rem1,
    output logic [PW-1:0] o_pay
);

    logic          r_valid;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num0, r_num1, r_quo0, r_quo1, n_quo0, n_quo1;
    logic [DW-1:0] r_rem0, r_rem1, n_rem0, n_rem1;
    logic [PW-1:0] r_pay;
    logic [DW:0]   w_t0, w_t1, w_d0, w_d1, w_den;
    logic          w_ge0, w_ge1;

    always_comb begin
        w_den  = {1'b0, i_den};
        w_t0   = {i_rem0, i_num0[NW-1]};
        w_t1   = {i_rem1, i_num1[NW-1]};
        w_d0   = w_t0 - w_den;
        w_d1   = w_t1 - w_den;
        w_ge0  = (w_t0 >= w_den);
        w_ge1  = (w_t1 >= w_den);
        n_rem0 = w_ge0 ? w_d0[DW-1:0] : w_t0[DW-1:0];
        n_rem1 = w_ge1 ? w_d1[DW-1:0] : w_t1[DW-1:0];
        n_quo0 = {i_quo0[NW-2:0], w_ge0};
        n_quo1 = {i_quo1[NW-2:0], w_ge1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_den  <= i_den;
        r_num0 <= {i_num0[NW-2:0], 1'b0};
        r_num1 <= {i_num1[NW-2:0], 1'b0};
        r_quo0 <= n_quo0;
        r_quo1 <= n_quo1;
        r_rem0 <= n_rem0;
        r_rem1 <= n_rem1;
        r_pay  <= i_pay;
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_num0  = r_num0;
    assign o_num1  = r_num1;
    assign o_quo0  = r_quo0;
    assign o_quo1  = r_quo1;
    assign o_rem0  = r_rem0;
    assign o_rem1  = r_rem1;
    assign o_pay   = r_pay;

endmodule

`default_nettype wire

@@ sv/quadratic_root_solver.sv @@
// Top level of the fixed-point quadratic root solver.
//
// A transaction is accepted at each rising edge where start is high and busy
// is low. busy is always low, so one transaction may be issued every cycle.
// The coefficients a, b and c are signed fixed-point words.
// Each transaction yields exactly one result, shown for one cycle with o_valid
// high, in issue order.
// Stages: input, products, discriminant, square root chain, numerators,
// divider chain, sign and saturation, ordering. Default format is Q16.16.
// The square root chain resolves one root bit per cell, and the divider chain
// resolves one quotient bit of both roots per cell.
// Throughput is one transaction per cycle.
// A synchronous reset clears all valid flags, dropping transactions in flight.
// The receiver cannot stall; each result must be taken in its cycle.
`default_nettype none

module quadratic_root_solver import qrs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] i_coef_a,
    input  logic [WORD_BITS-1:0] i_coef_b,
    input  logic [WORD_BITS-1:0] i_coef_c,
    output logic                 busy,
    output logic                 o_valid,
    output logic [1:0]           o_root_count,
    output logic [WORD_BITS-1:0] o_root_low,
    output logic [WORD_BITS-1:0] o_root_high,
    output logic                 o_degenerate,
    output logic                 o_overflow
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int RW  = W + F + 1;
    localparam int NW  = W + F + 2;
    localparam int DW  = W + 1;
    localparam int SPW = 5 + 2 * W;
    localparam int DPW = 6;

    // Input stage.
    logic         r0_valid, r0_na, r0_nb, r0_nc;
    logic [W-1:0] r0_ma, r0_mb, r0_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start & ~busy;
        end
        r0_na <= i_coef_a[W-1];
        r0_nb <= i_coef_b[W-1];
        r0_nc <= i_coef_c[W-1];
        r0_ma <= i_coef_a[W-1] ? (~i_coef_a + 1'b1) : i_coef_a;
        r0_mb <= i_coef_b[W-1] ? (~i_coef_b + 1'b1) : i_coef_b;
        r0_mc <= i_coef_c[W-1] ? (~i_coef_c + 1'b1) : i_coef_c;
    end

    // Products.
    logic           r1_valid, r1_na, r1_nb, r1_s4;
    logic [W-1:0]   r1_ma, r1_mb;
    logic [2*W-1:0] r1_bb, r1_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_na <= r0_na;
        r1_nb <= r0_nb;
        r1_s4 <= r0_na ^ r0_nc;
        r1_ma <= r0_ma;
        r1_mb <= r0_mb;
        r1_bb <= r0_mb * r0_mb;
        r1_ac <= r0_ma * r0_mc;
    end

    // Discriminant.
    logic signed [2*W+1:0] w_bbx, w_acx, w_d, w_dn;
    logic                  r2_valid, r2_na, r2_nb, r2_dneg, r2_one, r2_degen;
    logic [W-1:0]          r2_ma, r2_mb;
    logic [2*W:0]          r2_dmag;

    always_comb begin
        w_bbx = $signed({2'b00, r1_bb});
        w_acx = $signed({r1_ac, 2'b00});
        w_d   = r1_s4 ? (w_bbx + w_acx) : (w_bbx - w_acx);
        w_dn  = -w_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_na    <= r1_na;
        r2_nb    <= r1_nb;
        r2_ma    <= r1_ma;
        r2_mb    <= r1_mb;
        r2_degen <= (r1_ma == '0);
        r2_dneg  <= w_d[2*W+1];
        r2_one   <= (w_d == '0);
        r2_dmag  <= w_d[2*W+1] ? w_dn[2*W:0] : w_d[2*W:0];
    end

    // Square root chain.
    logic              w_sv   [0:RW];
    logic [2*RW-1:0]   w_srad [0:RW];
    logic [RW-1:0]     w_sroot[0:RW];
    logic [RW+1:0]     w_srem [0:RW];
    logic [SPW-1:0]    w_spay [0:RW];

    assign w_sv[0]    = r2_valid;
    assign w_srad[0]  = {1'b0, r2_dmag, {(2*F){1'b0}}};
    assign w_sroot[0] = '0;
    assign w_srem[0]  = '0;
    assign w_spay[0]  = {r2_degen, r2_dneg, r2_one, r2_na, r2_nb, r2_ma, r2_mb};

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        qrs_sqrt_cell #(.RW(RW), .PW(SPW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_sv[g]),
            .i_rad  (w_srad[g]),
            .i_root (w_sroot[g]),
            .i_rem  (w_srem[g]),
            .i_pay  (w_spay[g]),
            .o_valid(w_sv[g+1]),
            .o_rad  (w_srad[g+1]),
            .o_root (w_sroot[g+1]),
            .o_rem  (w_srem[g+1]),
            .o_pay  (w_spay[g+1])
        );
    end

    // Numerators.
    logic              s_degen, s_dneg, s_one, s_na, s_nb;
    logic [W-1:0]      s_ma, s_mb;
    logic signed [NW:0] w_sp, w_negb, w_ss, w_n0, w_n1, w_n0n, w_n1n;
    logic              r3_valid;
    logic [NW-1:0]     r3_num0, r3_num1;
    logic [DW-1:0]     r3_den;
    logic [DPW-1:0]    r3_pay;

    assign {s_degen, s_dneg, s_one, s_na, s_nb, s_ma, s_mb} = w_spay[RW];

    always_comb begin
        w_sp   = $signed({3'b000, s_mb, {F{1'b0}}});
        w_negb = s_nb ? w_sp : -w_sp;
        w_ss   = $signed({2'b00, w_sroot[RW]});
        w_n0   = w_negb + w_ss;
        w_n1   = w_negb - w_ss;
        w_n0n  = -w_n0;
        w_n1n  = -w_n1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= w_sv[RW];
        end
        r3_num0 <= w_n0[NW] ? w_n0n[NW-1:0] : w_n0[NW-1:0];
        r3_num1 <= w_n1[NW] ? w_n1n[NW-1:0] : w_n1[NW-1:0];
        r3_den  <= {s_ma, 1'b0};
        r3_pay  <= {s_degen, s_dneg, s_one, s_na, w_n0[NW], w_n1[NW]};
    end

    // Divider chain.
    logic           w_dv   [0:NW];
    logic [DW-1:0]  w_dden [0:NW];
    logic [NW-1:0]  w_dnum0[0:NW];
    logic [NW-1:0]  w_dnum1[0:NW];
    logic [NW-1:0]  w_dquo0[0:NW];
    logic [NW-1:0]  w_dquo1[0:NW];
    logic [DW-1:0]  w_drem0[0:NW];
    logic [DW-1:0]  w_drem1[0:NW];
    logic [DPW-1:0] w_dpay [0:NW];

    assign w_dv[0]    = r3_valid;
    assign w_dden[0]  = r3_den;
    assign w_dnum0[0] = r3_num0;
    assign w_dnum1[0] = r3_num1;
    assign w_dquo0[0] = '0;
    assign w_dquo1[0] = '0;
    assign w_drem0[0] = '0;
    assign w_drem1[0] = '0;
    assign w_dpay[0]  = r3_pay;

    for (genvar g = 0; g < NW; g++) begin : g_div
        qrs_div_cell #(.NW(NW), .DW(DW), .PW(DPW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_dv[g]),
            .i_den  (w_dden[g]),
            .i_num0 (w_dnum0[g]),
            .i_num1 (w_dnum1[g]),
            .i_quo0 (w_dquo0[g]),
            .i_quo1 (w_dquo1[g]),
            .i_rem0 (w_drem0[g]),
            .i_rem1 (w_drem1[g]),
            .i_pay  (w_dpay[g]),
            .o_valid(w_dv[g+1]),
            .o_den  (w_dden[g+1]),
            .o_num0 (w_dnum0[g+1]),
            .o_num1 (w_dnum1[g+1]),
            .o_quo0 (w_dquo0[g+1]),
            .o_quo1 (w_dquo1[g+1]),
            .o_rem0 (w_drem0[g+1]),
            .o_rem1 (w_drem1[g+1]),
            .o_pay  (w_dpay[g+1])
        );
    end

    // Sign and saturation.
    logic          d_degen, d_dneg, d_one, d_na, d_rs0, d_rs1;
    logic          w_qs0, w_qs1, w_sat0, w_sat1;
    logic [NW-1:0] w_lim0, w_lim1;
    logic [W-1:0]  w_m0, w_m1;
    logic          r4_valid, r4_degen, r4_dneg, r4_one, r4_ovf;
    logic [W-1:0]  r4_root0, r4_root1;

    assign {d_degen, d_dneg, d_one, d_na, d_rs0, d_rs1} = w_dpay[NW];

    always_comb begin
        w_qs0  = (d_rs0 ^ d_na) && (w_dquo0[NW] != '0);
        w_qs1  = (d_rs1 ^ d_na) && (w_dquo1[NW] != '0);
        w_lim0 = {{(NW-W){1'b0}}, w_qs0, {(W-1){~w_qs0}}};
        w_lim1 = {{(NW-W){1'b0}}, w_qs1, {(W-1){~w_qs1}}};
        w_sat0 = (w_dquo0[NW] > w_lim0);
        w_sat1 = (w_dquo1[NW] > w_lim1);
        w_m0   = w_sat0 ? w_lim0[W-1:0] : w_dquo0[NW][W-1:0];
        w_m1   = w_sat1 ? w_lim1[W-1:0] : w_dquo1[NW][W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= w_dv[NW];
        end
        r4_degen <= d_degen;
        r4_dneg  <= d_dneg;
        r4_one   <= d_one;
        r4_ovf   <= w_sat0 | w_sat1;
        r4_root0 <= w_qs0 ? (~w_m0 + 1'b1) : w_m0;
        r4_root1 <= w_qs1 ? (~w_m1 + 1'b1) : w_m1;
    end

    // Ordering and result register.
    logic         r5_valid, r5_degen, r5_ovf;
    logic [1:0]   r5_count;
    logic [W-1:0] r5_low, r5_high;
    logic         w_swap;

    assign w_swap = ($signed(r4_root0) > $signed(r4_root1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        if (r4_degen || r4_dneg) begin
            r5_count <= CNT_NONE;
            r5_low   <= '0;
            r5_high  <= '0;
            r5_ovf   <= 1'b0;
        end else begin
            r5_count <= r4_one ? CNT_ONE : CNT_TWO;
            r5_low   <= w_swap ? r4_root1 : r4_root0;
            r5_high  <= w_swap ? r4_root0 : r4_root1;
            r5_ovf   <= r4_ovf;
        end
        r5_degen <= r4_degen;
    end

    assign busy         = 1'b0;
    assign o_valid      = r5_valid;
    assign o_root_count = r5_count;
    assign o_root_low   = r5_low;
    assign o_root_high  = r5_high;
    assign o_degenerate = r5_degen;
    assign o_overflow   = r5_ovf;

`ifndef SYNTHESIS
    a_degen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> (o_root_count == CNT_NONE) && !o_overflow)
        else $error("degenerate result carries roots");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == CNT_TWO) |-> $signed(o_root_low) <= $signed(o_root_high))
        else $error("roots out of order");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == CNT_ONE) |-> o_root_low == o_root_high)
        else $error("single root differs");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == CNT_NONE) |-> (o_root_low == '0) && (o_root_high == '0))
        else $error("no-root result not zero");
`endif

endmodule

`default_nettype wire
